[sv/ostt_pkg.sv]
package ostt_pkg;

	// Default table geometry
	localparam int SLOTS_DEF     = 16;
	localparam int TIME_BITS_DEF = 32;

	// Widest time value any configuration may use
	localparam int WIDE_W = 64;

	// Firings reported by one tick at most, and the counter that tracks them
	localparam int MAX_RESULTS = 16;
	localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

	// Operation codes
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ZERO_DUR  = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] duration_ms;
		logic [3:0]  slot;
		logic [15:0] delta_ms;
	} req_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot_out;
		logic       fired;
		logic       last;
	} rsp_beat_t;

endpackage

[sv/ostt_stream_if.sv]
interface ostt_stream_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

[sv/one_shot_timer_table.sv]
// One-shot timer table: SLOTS timers, times in integer milliseconds.
//
// Channels: req (sink) carries operation, duration_ms, slot and delta_ms;
// rsp (source) carries status, slot_out, fired and last. A beat moves when
// valid and ready are both high. Every request gives one or more response
// beats; the final one has last set.
//
// Sequencing: remove and clear-all act when the request is taken, then pass
// through S_RESP into the output register. Add walks the armed bits one
// slot a cycle. Tick streams the slot memory through a read-modify-write loop
// at one slot a cycle while no held firing waits on the receiver. One request
// is in work at a time; req.ready is high whenever the sequencer is idle, also
// while a finished beat still waits in the output register.
//
// Reset frees every slot at once (armed bits are flip-flops); durations and
// elapsed times live in memory and are written on add. A stalled receiver holds
// the output register; a tick pauses its slot walk while a firing cannot leave.
module one_shot_timer_table_core #(
	parameter int SLOTS     = ostt_pkg::SLOTS_DEF,
	parameter int TIME_BITS = ostt_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ostt_stream_if.sink          req,
	ostt_stream_if.source        rsp
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int MEM_W = 2 * TIME_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_TICK = 2'd1;
	localparam logic [1:0] S_ADD  = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	function automatic logic [3:0] slot4(input logic [IDX_W-1:0] idx);
		logic [8:0] ext;
		ext = 9'(idx);
		return ext[3:0];
	endfunction

	logic [1:0]                  state_q;
	logic [SLOTS-1:0]            armed_q;
	logic [IDX_W-1:0]            idx_q;
	logic [TIME_BITS-1:0]        dur_q;
	logic [TIME_BITS-1:0]        delta_q;
	logic [ostt_pkg::FIRE_CNT_W-1:0] fire_cnt_q;
	logic [1:0]                  rsp_status_q;
	logic [IDX_W-1:0]            rsp_slot_q;
	logic                        rsp_fired_q;
	logic                        rsp_valid_q;
	ostt_pkg::rsp_beat_t         rsp_beat_q;

	logic                        req_fire;
	logic                        out_free;
	logic [ostt_pkg::WIDE_W-1:0] dur_wide;
	logic [ostt_pkg::WIDE_W-1:0] delta_wide;
	logic [TIME_BITS-1:0]        dur_in;
	logic [TIME_BITS-1:0]        delta_in;
	logic [8:0]                  rm_ext;
	logic [IDX_W-1:0]            rm_idx;
	logic                        rm_in_range;

	logic [MEM_W-1:0]            rd_data;
	logic [TIME_BITS-1:0]        rd_dur;
	logic [TIME_BITS-1:0]        rd_ela;
	logic [TIME_BITS:0]          sum;
	logic [TIME_BITS-1:0]        new_ela;
	logic                        cur_armed;
	logic                        fire;
	logic                        stall;
	logic                        last_idx;

	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	logic [MEM_W-1:0]            ram_wdata;
	logic                        ram_re;
	logic [IDX_W-1:0]            ram_raddr;

	logic                        rsp_load;
	ostt_pkg::rsp_beat_t         rsp_next;

	// Decode request fields
	assign req_fire    = req.valid && req.ready;
	assign out_free    = !rsp_valid_q || rsp.ready;
	assign dur_wide    = ostt_pkg::WIDE_W'(req.data.duration_ms);
	assign delta_wide  = ostt_pkg::WIDE_W'(req.data.delta_ms);
	assign dur_in      = dur_wide[TIME_BITS-1:0];
	assign delta_in    = delta_wide[TIME_BITS-1:0];
	assign rm_ext      = 9'(req.data.slot);
	assign rm_idx      = rm_ext[IDX_W-1:0];
	assign rm_in_range = rm_ext < 9'(SLOTS);

	// Evaluate the slot whose entry is on the read port
	assign rd_dur    = rd_data[MEM_W-1:TIME_BITS];
	assign rd_ela    = rd_data[TIME_BITS-1:0];
	assign sum       = {1'b0, rd_ela} + {1'b0, delta_q};
	assign new_ela   = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
	assign cur_armed = armed_q[idx_q];
	assign fire      = cur_armed && (new_ela >= rd_dur) &&
	                   (fire_cnt_q < ostt_pkg::FIRE_CNT_W'(ostt_pkg::MAX_RESULTS));
	assign stall     = fire && rsp_fired_q && !out_free;
	assign last_idx  = idx_q == IDX_W'(SLOTS - 1);

	assign req.ready = state_q == S_IDLE;

	// Drive memory ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {rd_dur, new_ela};
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (req_fire && req.data.operation == ostt_pkg::OP_TICK) begin
					ram_re = 1'b1;
				end
			end
			S_TICK: begin
				if (!stall) begin
					ram_we = cur_armed;
					if (!last_idx) begin
						ram_re    = 1'b1;
						ram_raddr = idx_q + IDX_W'(1);
					end
				end
			end
			S_ADD: begin
				if (!cur_armed) begin
					ram_we    = 1'b1;
					ram_wdata = {dur_q, {TIME_BITS{1'b0}}};
				end
			end
			default: begin
			end
		endcase
	end

	// Pick the beat that enters the output register
	always_comb begin
		rsp_load = 1'b0;
		rsp_next = '{status: rsp_status_q, slot_out: slot4(rsp_slot_q),
		             fired: rsp_fired_q, last: 1'b1};
		case (state_q)
			S_TICK: begin
				if (!stall && fire && rsp_fired_q) begin
					rsp_load      = 1'b1;
					rsp_next.last = 1'b0;
				end
			end
			S_RESP: begin
				rsp_load = out_free;
			end
			default: begin
			end
		endcase
	end

	ostt_ram #(
		.DEPTH  (SLOTS),
		.WIDTH  (MEM_W),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// Sequencer and armed bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			armed_q     <= '0;
			rsp_fired_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						rsp_status_q <= ostt_pkg::ST_OK;
						rsp_slot_q   <= '0;
						rsp_fired_q  <= 1'b0;
						idx_q        <= '0;
						fire_cnt_q   <= '0;
						delta_q      <= delta_in;
						dur_q        <= dur_in;
						case (req.data.operation)
							ostt_pkg::OP_TICK: begin
								state_q <= S_TICK;
							end
							ostt_pkg::OP_ADD: begin
								if (dur_in == '0) begin
									rsp_status_q <= ostt_pkg::ST_ZERO_DUR;
									state_q      <= S_RESP;
								end else begin
									state_q <= S_ADD;
								end
							end
							ostt_pkg::OP_REMOVE: begin
								if (rm_in_range) begin
									armed_q[rm_idx] <= 1'b0;
								end
								state_q <= S_RESP;
							end
							default: begin
								armed_q <= '0;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_TICK: begin
					// Advance one slot unless a pending firing cannot leave
					if (!stall) begin
						if (fire) begin
							armed_q[idx_q] <= 1'b0;
							fire_cnt_q     <= fire_cnt_q + ostt_pkg::FIRE_CNT_W'(1);
							rsp_fired_q    <= 1'b1;
							rsp_slot_q     <= idx_q;
						end
						if (last_idx) begin
							state_q <= S_RESP;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				S_ADD: begin
					// Claim the lowest free slot, or report a full table
					if (!cur_armed) begin
						armed_q[idx_q] <= 1'b1;
						rsp_slot_q     <= idx_q;
						state_q        <= S_RESP;
					end else if (last_idx) begin
						rsp_status_q <= ostt_pkg::ST_TABLE_FULL;
						state_q      <= S_RESP;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_RESP: begin
					if (out_free) begin
						rsp_fired_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_beat_q <= rsp_next;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_beat_q;

endmodule

[sv/ostt_ram.sv]
module ostt_ram #(
	parameter int DEPTH  = ostt_pkg::SLOTS_DEF,
	parameter int WIDTH  = 2 * ostt_pkg::TIME_BITS_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/ostt_checker.sv]
module ostt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input ostt_pkg::rsp_beat_t rsp_data
);

	// A stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response beat changed while stalled");

	// One request in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// Only firings can be followed by more beats of the same request
	a_nonlast_fired: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.last |-> rsp_data.fired)
		else $error("non-final beat does not report a firing");

	// Rejections and full table end the request and name no slot
	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ostt_pkg::ST_OK |->
		rsp_data.last && !rsp_data.fired && rsp_data.slot_out == 4'd0)
		else $error("error beat carries slot, firing or continues");

endmodule

bind one_shot_timer_table_core ostt_checker u_ostt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
